### rtl/core/mbet_pkg.sv
// Package for the Mandelbrot escape-time unit: beat types and default constants.
// No dependencies; used by mandelbrot_escape_time_top.
`default_nettype none

package mbet_pkg;

   localparam int DATA_W          = 32;
   localparam int COUNT_W         = 16;
   localparam int FRAC_BITS_DEF   = 28;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd1000;

   typedef struct packed {
      logic signed [DATA_W-1:0] c_re;
      logic signed [DATA_W-1:0] c_im;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] escape_count;
      logic               inside_res;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/mandelbrot_escape_time_top.sv
// Mandelbrot escape-time unit: iterates z = z*z + c on one shared 32x32 multiplier.
// Depends on mbet_pkg for the beat types and reset constants.
`default_nettype none

// The block takes one point c per request beat (signed fixed point with FRAC_BITS
// fraction bits) and returns one response beat with the iteration count at which
// |z|^2 first exceeded four, or the inside flag with a count of zero when no step
// escaped below max_iterations. A single signed 32x32 multiplier, registered at
// its output, is shared by the three products of every step (re*re, im*im and
// re*im), so each step of the recurrence runs three multiplier passes and then
// ST_UPDATE, which forms and saturates the new z. The escape test reuses the
// two squares of the following step, so it adds no multiplier pass. A point
// holds request stall high from the accepting edge until ST_DONE hands its
// result to the response register, whether it escapes or stays inside. The
// hand-over waits longer while an earlier result still sits on a stalled
// response channel, since a new point can be taken before that older beat has
// gone. Once request stall drops, the next point can be accepted at the
// following edge. The user must write the max_iterations register through the
// csr port only while idle; the block itself does not enforce this. It resets
// to 1000.
module mandelbrot_escape_time_top #(
   parameter int FRAC_BITS   = mbet_pkg::FRAC_BITS_DEF,
   parameter int COUNT_WIDTH = mbet_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire mbet_pkg::req_type              req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      mbet_pkg::rsp_type              rsp_data,
   input  wire logic                           csr_write_enable,
   input  wire logic [mbet_pkg::COUNT_W-1:0]   csr_write_data
);
   import mbet_pkg::*;

   localparam int PROD_W = 2 * DATA_W;

   // The escape threshold four at 2*FRAC_BITS fraction bits; when it does not fit
   // in the product width the test can never fire.
   localparam bit ESC_ENABLE = (2 * FRAC_BITS + 2) < PROD_W;
   localparam logic [PROD_W-1:0] ESC_LIMIT =
      ESC_ENABLE ? (PROD_W'(4) << (2 * FRAC_BITS)) : '0;

   // Reported count keeps only its low COUNT_WIDTH bits.
   localparam logic [COUNT_W-1:0] COUNT_MASK =
      (COUNT_WIDTH >= COUNT_W) ? {COUNT_W{1'b1}}
                               : COUNT_W'((64'd1 << COUNT_WIDTH) - 64'd1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        max_iter_ff, max_iter_in;
   logic signed [DATA_W-1:0]  c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [DATA_W-1:0]  z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic [COUNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  rr_ff, rr_in, ii_ff, ii_in;
   rsp_type                   res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic signed [DATA_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0]         mag;
   logic                      escaped;
   logic                      last_step;
   logic signed [PROD_W-1:0]  diff, new_re, new_im;

   function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      begin
         hi = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
         lo = -hi - PROD_W'(1);
         if (v > hi) begin
            sat_word = hi[DATA_W-1:0];
         end else if (v < lo) begin
            sat_word = lo[DATA_W-1:0];
         end else begin
            sat_word = v[DATA_W-1:0];
         end
      end
   endfunction

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = z_re_ff;
      mul_b = z_re_ff;
      unique case (state_ff)
         ST_SQ_IM: begin
            mul_a = z_im_ff;
            mul_b = z_im_ff;
         end
         ST_CROSS: begin
            mul_a = z_re_ff;
            mul_b = z_im_ff;
         end
         default: begin
            mul_a = z_re_ff;
            mul_b = z_re_ff;
         end
      endcase
   end

   // In ST_CROSS rr_ff holds re^2 and prod_ff holds im^2 of the current z.
   assign mag       = rr_ff + prod_ff;
   assign escaped   = ESC_ENABLE && (cnt_ff != '0) && (mag > ESC_LIMIT);
   assign last_step = ({1'b0, cnt_ff} + 17'd1) >= {1'b0, max_iter_ff};

   // New z from the registered products; prod_ff holds re*im in ST_UPDATE.
   assign diff   = rr_ff - ii_ff;
   assign new_re = (diff >>> FRAC_BITS) + PROD_W'(c_re_ff);
   assign new_im = (prod_ff >>> (FRAC_BITS - 1)) + PROD_W'(c_im_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      max_iter_in  = max_iter_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      z_re_in      = z_re_ff;
      z_im_in      = z_im_ff;
      cnt_in       = cnt_ff;
      // Both operands are sign-extended 32-bit words, so this stays a 32x32 product.
      prod_in      = PROD_W'(mul_a) * PROD_W'(mul_b);
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_enable) begin
         max_iter_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               c_re_in  = req_data.c_re;
               c_im_in  = req_data.c_im;
               z_re_in  = '0;
               z_im_in  = '0;
               cnt_in   = '0;
               state_in = ST_SQ_RE;
            end
         end
         ST_SQ_RE: begin
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            rr_in    = prod_ff;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            ii_in = prod_ff;
            if (escaped) begin
               res_in.escape_count = cnt_ff & COUNT_MASK;
               res_in.inside_res   = 1'b0;
               state_in            = ST_DONE;
            end else if (last_step) begin
               res_in.escape_count = '0;
               res_in.inside_res   = 1'b1;
               state_in            = ST_DONE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            z_re_in  = sat_word(new_re);
            z_im_in  = sat_word(new_im);
            cnt_in   = cnt_ff + COUNT_W'(1);
            state_in = ST_SQ_RE;
         end
         ST_DONE: begin
            // Wait here while an older result still sits stalled on the output.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_iter_ff  <= MAX_ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_iter_ff  <= max_iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_re_ff     <= c_re_in;
      c_im_ff     <= c_im_in;
      z_re_ff     <= z_re_in;
      z_im_ff     <= z_im_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      rr_ff       <= rr_in;
      ii_ff       <= ii_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### dv/mandelbrot_escape_time_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for mandelbrot_escape_time_top: directed and random points of c, each
// predicted in the bench and checked against the escape count and inside flag returned.
// Depends on mbet_pkg and the mandelbrot_escape_time_top RTL.

module mandelbrot_escape_time_top_test;
   import mbet_pkg::*;

   // How the two channels idle during a phase of the run.
   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int FRAC = FRAC_BITS_DEF;

   // |z|^2 is compared against four held with twice the fraction bits.
   localparam longint unsigned RADIUS_SQ = 64'd4 << (2 * FRAC);

   localparam int Q_MAX = 32'sh7fff_ffff;
   localparam int Q_MIN = 32'sh8000_0000;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   req_type            req_data         = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   rsp_type            rsp_data;
   logic               csr_write_enable = 1'b0;
   logic [COUNT_W-1:0] csr_write_data   = MAX_ITER_RESET;

   // The bench's own copy of the iteration limit, followed on every register write.
   int unsigned        iter_limit       = MAX_ITER_RESET;
   idle_mode_type      idle_mode        = IDLE_NONE;
   bit                 hold_points      = 1'b0;

   // Points still to be sent, and the results owed for points already accepted.
   req_type            pending_points[$];
   rsp_type            expected_escapes[$];

   int unsigned        mismatch_count   = 0;
   int unsigned        points_sent      = 0;
   int unsigned        escaped_seen     = 0;
   int unsigned        inside_seen      = 0;
   longint unsigned    cycle_count      = 0;
   // Grows with every queued point by many times the worst case that point can cost.
   longint unsigned    cycle_limit      = 20000;

   int unsigned        tiny_limits[3]   = '{0, 1, 2};

   mandelbrot_escape_time_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Escape-time prediction for one point. z starts at zero; each step squares it, adds c
   // and saturates both parts to 32 bits, and the first step whose |z|^2 exceeds four is
   // the count. The arithmetic shifts round towards minus infinity, as the block's do.
   function automatic rsp_type escape_time_of(req_type c, int unsigned limit);
      longint          zr;
      longint          zi;
      longint          nr;
      longint          ni;
      longint unsigned ar;
      longint unsigned ai;
      rsp_type         r;
      zr = 0;
      zi = 0;
      r.escape_count = '0;
      r.inside_res   = 1'b1;
      for (int unsigned step = 1; step < limit; step++) begin
         nr = ((zr * zr - zi * zi) >>> FRAC) + longint'(c.c_re);
         ni = ((zr * zi) >>> (FRAC - 1)) + longint'(c.c_im);
         zr = (nr > Q_MAX) ? Q_MAX : (nr < Q_MIN) ? Q_MIN : nr;
         zi = (ni > Q_MAX) ? Q_MAX : (ni < Q_MIN) ? Q_MIN : ni;
         ar = (zr < 0) ? -zr : zr;
         ai = (zi < 0) ? -zi : zi;
         if (ar * ar + ai * ai > RADIUS_SQ) begin
            r.escape_count = COUNT_W'(step);
            r.inside_res   = 1'b0;
            break;
         end
      end
      return r;
   endfunction

   // Converts a real coordinate to the block's fixed-point format.
   function automatic int fixq(real x);
      return int'(x * (2.0 ** FRAC));
   endfunction

   function automatic req_type point(int re, int im);
      req_type p;
      p.c_re = re;
      p.c_im = im;
      return p;
   endfunction

   // Most random points lie in the box around the set, where escape counts vary widely;
   // the rest are raw 32-bit patterns that exercise every bit and mostly escape at once.
   function automatic req_type random_point();
      if ($urandom_range(99) < 70) begin
         return point(fixq(-2.25) + int'($urandom_range(fixq(3.0))),
                      fixq(-1.5) + int'($urandom_range(fixq(3.0))));
      end else begin
         return point($urandom, $urandom);
      end
   endfunction

   task automatic flag_mismatch(string what);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic queue_point(req_type p);
      pending_points.push_back(p);
      cycle_limit += 16 * longint'(iter_limit) + 400;
   endtask

   // Returns once every queued point has been sent and every owed result has arrived.
   task automatic wait_idle();
      while (pending_points.size() != 0 || req_valid || expected_escapes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // The limit may only change while the block is idle, so drain it first.
   task automatic set_iteration_limit(int unsigned value);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= COUNT_W'(value);
      iter_limit       <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(int unsigned limit, idle_mode_type mode, int unsigned count,
                             bit pause_midway);
      set_iteration_limit(limit);
      idle_mode = mode;
      repeat (count) queue_point(random_point());
      // Halfway through, the sender holds back until the block has returned every result,
      // so that the next beat lands on a fully idle unit.
      if (pause_midway) begin
         while (pending_points.size() > count / 2) @(negedge clock);
         hold_points = 1'b1;
         while (req_valid || expected_escapes.size() != 0) @(negedge clock);
         hold_points = 1'b0;
      end
   endtask

   // Request driver. When a beat is accepted its result is predicted at once, with the
   // limit in force, and the next pending point is offered unless the sender rests or is held.
   always @(posedge clock) begin : point_driver
      bit resting;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_escapes.push_back(escape_time_of(req_data, iter_limit));
            points_sent++;
         end
         if (!req_valid || !req_stall) begin
            resting = (idle_mode == IDLE_SENDER && $urandom_range(99) < 73) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 34);
            if (pending_points.size() != 0 && !hold_points && !resting) begin
               req_valid <= 1'b1;
               req_data  <= pending_points.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every accepted result beat is matched against the oldest owed
   // result, field by field; the stall is redrawn each cycle in the stalling phases.
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_escapes.size() == 0) begin
               flag_mismatch($sformatf("result beat with no point outstanding (count %0d)",
                                       rsp_data.escape_count));
            end else begin
               want = expected_escapes.pop_front();
               if (rsp_data.escape_count !== want.escape_count) begin
                  flag_mismatch($sformatf("escape_count %0d, predicted %0d",
                                          rsp_data.escape_count, want.escape_count));
               end
               if (rsp_data.inside_res !== want.inside_res) begin
                  flag_mismatch($sformatf("inside_res %b, predicted %b",
                                          rsp_data.inside_res, want.inside_res));
               end
               if (want.inside_res) begin
                  inside_seen++;
               end else begin
                  escaped_seen++;
               end
            end
         end
         rsp_stall <= (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 73) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 34);
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("timed out after %0d cycles with %0d results owed", cycle_count,
                  expected_escapes.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed points under the reset limit: field extremes, the origin, points exactly on
      // the radius-two circle (where |z|^2 of four must not count as escaped), the slow cusp
      // at one quarter, periodic interior points and points that escape after a few dozen steps.
      queue_point(point(0, 0));
      queue_point(point(Q_MAX, Q_MAX));
      queue_point(point(Q_MIN, Q_MIN));
      queue_point(point(Q_MAX, Q_MIN));
      queue_point(point(Q_MIN, Q_MAX));
      queue_point(point(fixq(-2.0), 0));
      queue_point(point(fixq(-2.0) - 1, 0));
      queue_point(point(fixq(2.0), 0));
      queue_point(point(0, fixq(2.0)));
      queue_point(point(0, fixq(-2.0)));
      queue_point(point(fixq(0.25), 0));
      queue_point(point(0, fixq(1.0)));
      queue_point(point(fixq(-1.0), 0));
      queue_point(point(fixq(0.26), 0));
      queue_point(point(-1, 1));
      queue_point(point(fixq(-0.75), fixq(0.1)));

      // The largest limit: one interior point runs the full count, one escapes after some
      // hundreds of steps, one escapes at once.
      set_iteration_limit(65535);
      queue_point(point(0, 0));
      queue_point(point(fixq(0.2501), 0));
      queue_point(point(Q_MIN, Q_MAX));

      // Limits of zero and one run no step at all, and a limit of two runs exactly one, so
      // of the directed points only the one just beyond the circle escapes there.
      foreach (tiny_limits[k]) begin
         set_iteration_limit(tiny_limits[k]);
         queue_point(point(0, 0));
         queue_point(point(fixq(2.0), 0));
         queue_point(point(fixq(2.0) + 1, 0));
         repeat (6) queue_point(random_point());
      end

      run_random(24, IDLE_NONE, 130, 1'b0);
      run_random(100, IDLE_SENDER, 130, 1'b0);
      run_random(7, IDLE_RECEIVER, 120, 1'b0);
      run_random(250, IDLE_BOTH, 120, 1'b1);

      wait_idle();
      repeat (32) @(posedge clock);

      $display("%0d points over limits from 0 to 65535: %0d escaped, %0d inside",
               points_sent, escaped_seen, inside_seen);
      $display("phases without idling, with sender gaps, receiver stalls and both; %0d errors",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
